>>> hdl/srr_pkg.sv
`default_nettype none

package srr_pkg;

  // fixed field widths
  localparam int KIND_W     = 2;
  localparam int SEQ_W      = 31;
  localparam int LEN_W      = 11;
  localparam int SLOT_OUT_W = 5;
  localparam int SAT_W      = 16;

  // arriving message kinds; the other codes are ignored
  localparam logic [KIND_W-1:0] MSG_DATA = 2'd0;
  localparam logic [KIND_W-1:0] MSG_FIN  = 2'd1;

  typedef enum logic [1:0] {
    RES_DELIVER = 2'd0,
    RES_STORE   = 2'd1,
    RES_ACK     = 2'd2,
    RES_FINACK  = 2'd3
  } res_kind_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAL,
    ST_DLV_ARR,
    ST_DRAIN_RD,
    ST_DRAIN,
    ST_STORE,
    ST_ACK,
    ST_FIN
  } ctl_state_t;

  typedef struct packed {
    logic      load;
    logic      clear_step;
    logic      emit;
    res_kind_t res_kind;
    logic      arrival;
    logic      take_head;
    logic      store;
    logic      set_closed;
  } ctl_cmd_t;

  typedef struct packed {
    logic              clear_last;
    logic              out_free;
    logic              closed;
    logic [KIND_W-1:0] kind;
    logic              seq_eq;
    logic              seq_gt;
    logic              in_window;
    logic              head_valid;
  } ctl_status_t;

endpackage

`default_nettype wire

>>> hdl/selective_repeat_reorder_receiver.sv
// channel   direction  handshake            word
// in        input      in_valid / in_ready  msg_kind, seq_number, payload_length
// out       output     out_valid / out_ready result_kind, slot_index, delivered_length,
//                                           from_arrival, ack_number, dropped, last_of_run
//
// steps: header accept, decode, then the arrival, store or ack word; a delivery
//   run adds a registered slot read and a check for each buffered slot plus one read
//   that finds the end of the run
// ignored kinds and headers after close give no word
// reset: a clearing pass walks the slot memory, in_ready stays low
// stalls: out_ready low holds the controller in its result state; one output
//   register decouples the sides, one header is worked at a time
`default_nettype none

module selective_repeat_reorder_receiver #(
  parameter int WINDOW      = 32,
  parameter int MAX_PAYLOAD = 2000
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [srr_pkg::KIND_W-1:0]        msg_kind,
  input  logic [srr_pkg::SEQ_W-1:0]         seq_number,
  input  logic [srr_pkg::LEN_W-1:0]         payload_length,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [1:0]                       result_kind,
  output logic [srr_pkg::SLOT_OUT_W-1:0]    slot_index,
  output logic [srr_pkg::LEN_W-1:0]         delivered_length,
  output logic                             from_arrival,
  output logic [srr_pkg::SEQ_W-1:0]         ack_number,
  output logic                             dropped,
  output logic                             last_of_run
);

  import srr_pkg::*;

  // command and status between sequencer and datapath
  ctl_cmd_t    cmd;
  ctl_status_t status;

  // sequencer: clearing pass, header decode, deliver / drain / store / ack / fin ack
  srr_controller u_ctl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath: header latch, expected sequence, head pointer, slot memory,
  // output register
  srr_datapath #(
    .WINDOW      (WINDOW),
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .msg_kind         (msg_kind),
    .seq_number       (seq_number),
    .payload_length   (payload_length),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .result_kind      (result_kind),
    .slot_index       (slot_index),
    .delivered_length (delivered_length),
    .from_arrival     (from_arrival),
    .ack_number       (ack_number),
    .dropped          (dropped),
    .last_of_run      (last_of_run)
  );

endmodule

`default_nettype wire

>>> hdl/srr_ram.sv
`default_nettype none

module srr_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 32,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

>>> hdl/srr_controller.sv
`default_nettype none

module srr_controller (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  srr_pkg::ctl_status_t status,
  output srr_pkg::ctl_cmd_t    cmd
);

  import srr_pkg::*;

  ctl_state_t state;
  ctl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (status.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_next = ST_EVAL;
      end
      ST_EVAL: begin
        if (status.closed) begin
          state_next = ST_IDLE;
        end else if (status.kind == MSG_FIN) begin
          state_next = ST_FIN;
        end else if (status.kind != MSG_DATA) begin
          state_next = ST_IDLE;
        end else if (status.seq_eq) begin
          state_next = ST_DLV_ARR;
        end else if (status.seq_gt && status.in_window) begin
          state_next = ST_STORE;
        end else begin
          state_next = ST_ACK;
        end
      end
      ST_DLV_ARR: begin
        if (status.out_free) state_next = ST_DRAIN_RD;
      end
      ST_DRAIN_RD: begin
        state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!status.head_valid) begin
          state_next = ST_ACK;
        end else if (status.out_free) begin
          state_next = ST_DRAIN_RD;
        end
      end
      ST_STORE: begin
        if (status.out_free) state_next = ST_ACK;
      end
      ST_ACK: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      ST_FIN: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_EVAL, ST_DRAIN_RD: begin
      end
      ST_DLV_ARR: begin
        cmd.res_kind = RES_DELIVER;
        cmd.arrival  = 1'b1;
        if (status.out_free) begin
          cmd.emit      = 1'b1;
          cmd.take_head = 1'b1;
        end
      end
      ST_DRAIN: begin
        cmd.res_kind = RES_DELIVER;
        if (status.head_valid && status.out_free) begin
          cmd.emit      = 1'b1;
          cmd.take_head = 1'b1;
        end
      end
      ST_STORE: begin
        cmd.res_kind = RES_STORE;
        if (status.out_free) begin
          cmd.emit  = 1'b1;
          cmd.store = 1'b1;
        end
      end
      ST_ACK: begin
        cmd.res_kind = RES_ACK;
        cmd.emit     = status.out_free;
      end
      ST_FIN: begin
        cmd.res_kind = RES_FINACK;
        if (status.out_free) begin
          cmd.emit       = 1'b1;
          cmd.set_closed = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> status.out_free)
    else $error("result issued while output register is occupied");

  a_fin_closes: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && cmd.res_kind == RES_FINACK) |=> status.closed)
    else $error("fin ack did not close the receiver");

  a_drain_follows_take: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAIN_RD) |-> $past(cmd.take_head))
    else $error("slot read without a preceding head advance");

endmodule

`default_nettype wire

>>> hdl/srr_datapath.sv
`default_nettype none

module srr_datapath #(
  parameter int WINDOW      = 32,
  parameter int MAX_PAYLOAD = 2000
) (
  input  logic                             clk,
  input  logic                             rst,
  input  srr_pkg::ctl_cmd_t                 cmd,
  output srr_pkg::ctl_status_t              status,
  input  logic [srr_pkg::KIND_W-1:0]        msg_kind,
  input  logic [srr_pkg::SEQ_W-1:0]         seq_number,
  input  logic [srr_pkg::LEN_W-1:0]         payload_length,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [1:0]                       result_kind,
  output logic [srr_pkg::SLOT_OUT_W-1:0]    slot_index,
  output logic [srr_pkg::LEN_W-1:0]         delivered_length,
  output logic                             from_arrival,
  output logic [srr_pkg::SEQ_W-1:0]         ack_number,
  output logic                             dropped,
  output logic                             last_of_run
);

  import srr_pkg::*;

  localparam int SLOT_W  = $clog2(WINDOW);
  localparam int ENTRY_W = LEN_W + 1;
  localparam logic [SLOT_W:0]    WIN_EXT   = (SLOT_W + 1)'(WINDOW);
  localparam logic [SLOT_W-1:0]  SLOT_LAST = SLOT_W'(WINDOW - 1);
  localparam logic [SEQ_W-1:0]   WIN_SEQ   = SEQ_W'(WINDOW);
  localparam logic [SAT_W-1:0]   MAX_LEN   = SAT_W'(MAX_PAYLOAD);

  // latched header
  logic [KIND_W-1:0] kind;
  logic [LEN_W-1:0]  len;
  logic [SEQ_W-1:0]  diff;
  logic              seq_eq;
  logic              seq_gt;

  // receiver state
  logic [SEQ_W-1:0]  next_expected;
  logic [SLOT_W-1:0] head;
  logic [SLOT_W-1:0] head_next;
  logic              closed;
  logic [SLOT_W-1:0] clear_cnt;

  logic [LEN_W-1:0]  len_sat;
  logic [SLOT_W:0]   store_sum;
  logic [SLOT_W-1:0] store_slot;
  logic              in_window;

  logic              ram_wr_en;
  logic [SLOT_W-1:0] ram_wr_addr;
  logic [ENTRY_W-1:0] ram_wr_data;
  logic [ENTRY_W-1:0] ram_rd_data;

  logic [SLOT_W-1:0]             slot_sel;
  logic [SLOT_OUT_W+SLOT_W-1:0]  slot_ext;
  logic [LEN_W-1:0]              len_sel;
  logic [SEQ_W-1:0]              ack_sel;
  logic                          arr_sel;
  logic                          drop_sel;
  logic                          last_sel;

  assign len_sat = ({{(SAT_W - LEN_W){1'b0}}, payload_length} > MAX_LEN) ?
                   MAX_LEN[LEN_W-1:0] : payload_length;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind   <= msg_kind;
      len    <= len_sat;
      diff   <= seq_number - next_expected;
      seq_eq <= (seq_number == next_expected);
      seq_gt <= (seq_number > next_expected);
    end
  end

  assign head_next  = (head == SLOT_LAST) ? '0 : head + 1'b1;
  assign in_window  = (diff < WIN_SEQ);
  assign store_sum  = {1'b0, head} + {1'b0, diff[SLOT_W-1:0]};
  assign store_slot = (store_sum >= WIN_EXT) ? SLOT_W'(store_sum - WIN_EXT)
                                             : store_sum[SLOT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      next_expected <= '0;
      head          <= '0;
      closed        <= 1'b0;
      clear_cnt     <= '0;
    end else begin
      if (cmd.clear_step) clear_cnt <= clear_cnt + 1'b1;
      if (cmd.take_head) begin
        head          <= head_next;
        next_expected <= next_expected + 1'b1;
      end
      if (cmd.set_closed) closed <= 1'b1;
    end
  end

  // slot entries: valid bit over stored length
  assign ram_wr_en   = cmd.clear_step | cmd.take_head | cmd.store;
  assign ram_wr_addr = cmd.clear_step ? clear_cnt : (cmd.store ? store_slot : head);
  assign ram_wr_data = cmd.store ? {1'b1, len} : '0;

  srr_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (WINDOW)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (head),
    .rd_data (ram_rd_data)
  );

  always_comb begin
    status            = '0;
    status.clear_last = (clear_cnt == SLOT_LAST);
    status.out_free   = !out_valid || out_ready;
    status.closed     = closed;
    status.kind       = kind;
    status.seq_eq     = seq_eq;
    status.seq_gt     = seq_gt;
    status.in_window  = in_window;
    status.head_valid = ram_rd_data[LEN_W];
  end

  // result field selection
  always_comb begin
    slot_sel = '0;
    len_sel  = '0;
    ack_sel  = '0;
    arr_sel  = 1'b0;
    drop_sel = 1'b0;
    last_sel = 1'b0;
    unique case (cmd.res_kind)
      RES_DELIVER: begin
        slot_sel = head;
        len_sel  = cmd.arrival ? len : ram_rd_data[LEN_W-1:0];
        arr_sel  = cmd.arrival;
      end
      RES_STORE: begin
        slot_sel = store_slot;
        len_sel  = len;
      end
      RES_ACK: begin
        ack_sel  = next_expected;
        drop_sel = seq_gt && !in_window;
        last_sel = 1'b1;
      end
      RES_FINACK: begin
        ack_sel  = next_expected;
        last_sel = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign slot_ext = {{SLOT_OUT_W{1'b0}}, slot_sel};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result_kind      <= cmd.res_kind;
      slot_index       <= slot_ext[SLOT_OUT_W-1:0];
      delivered_length <= len_sel;
      from_arrival     <= arr_sel;
      ack_number       <= ack_sel;
      dropped          <= drop_sel;
      last_of_run      <= last_sel;
    end
  end

  a_one_writer: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.clear_step, cmd.take_head, cmd.store}))
    else $error("more than one slot write source active");

  a_expect_moves_on_take: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && next_expected != $past(next_expected)) |-> $past(cmd.take_head))
    else $error("expected sequence moved without a delivery");

endmodule

`default_nettype wire

>>> test/selective_repeat_reorder_receiver_tb.sv
`default_nettype none

module selective_repeat_reorder_receiver_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import srr_pkg::*;

  localparam int WIN         = 32;
  localparam int MAX_LEN     = 2000;
  localparam int RAND_ITEMS  = 345;
  // settle time after the last result
  localparam int SETTLE_CYCLES  = 100;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int HOLD_AT_WORD   = 150;
  localparam int PAUSE_AT_ITEM  = 200;
  localparam int CALM_TAIL      = 40;

  // ignored header kinds
  localparam logic [KIND_W-1:0] MSG_OTHER = 2'd2;
  localparam logic [KIND_W-1:0] MSG_RSVD  = 2'd3;

  // two copies of the receiver state: one steers the stimulus, one checks
  localparam int PLAN = 0;
  localparam int CHK  = 1;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SEQ_W-1:0]  seq;
    logic [LEN_W-1:0]  len;
    logic              drain_first;
  } hdr_t;

  typedef struct packed {
    res_kind_t             kind;
    logic [SLOT_OUT_W-1:0] slot;
    logic [LEN_W-1:0]      len;
    logic                  arrival;
    logic [SEQ_W-1:0]      ack;
    logic                  drop;
    logic                  last;
  } rx_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  in_valid       = 1'b0;
  logic                  in_ready;
  logic [KIND_W-1:0]     msg_kind       = '0;
  logic [SEQ_W-1:0]      seq_number     = '0;
  logic [LEN_W-1:0]      payload_length = '0;
  logic                  out_valid;
  logic                  out_ready      = 1'b0;
  logic [1:0]            result_kind;
  logic [SLOT_OUT_W-1:0] slot_index;
  logic [LEN_W-1:0]      delivered_length;
  logic                  from_arrival;
  logic [SEQ_W-1:0]      ack_number;
  logic                  dropped;
  logic                  last_of_run;

  selective_repeat_reorder_receiver u_top (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .msg_kind         (msg_kind),
    .seq_number       (seq_number),
    .payload_length   (payload_length),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .result_kind      (result_kind),
    .slot_index       (slot_index),
    .delivered_length (delivered_length),
    .from_arrival     (from_arrival),
    .ack_number       (ack_number),
    .dropped          (dropped),
    .last_of_run      (last_of_run)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // receiver state copies
  logic [SEQ_W-1:0] next_seq  [2];
  int               head_pos  [2];
  logic             slot_full [2][WIN];
  logic [LEN_W-1:0] slot_len  [2][WIN];
  logic             is_closed [2];

  hdr_t     hdr_q[$];      // headers waiting to be offered
  rx_word_t due_words[$];  // result words predicted but not yet seen

  int unsigned mismatch_cnt = 0;
  int unsigned items_taken  = 0;
  int unsigned words_seen   = 0;
  int unsigned data_queued  = 0;
  int          gap_left     = 0;
  int          stall_left   = 0;
  int          stall_next;
  int          hold_left    = 0;
  logic        hold_done    = 1'b0;
  int          quiet_cycles = 0;
  logic        pause_next   = 1'b0;
  hdr_t        next_hdr;

  function automatic void clear_model();
    for (int c = 0; c < 2; c++) begin
      next_seq[c]  = '0;
      head_pos[c]  = 0;
      is_closed[c] = 1'b0;
      for (int s = 0; s < WIN; s++) begin
        slot_full[c][s] = 1'b0;
        slot_len[c][s]  = '0;
      end
    end
  endfunction

  function automatic void push_word(input int cp, input res_kind_t k, input int slot,
                                    input logic [LEN_W-1:0] len, input logic arrival,
                                    input logic [SEQ_W-1:0] ack, input logic drop,
                                    input logic last);
    rx_word_t w;
    if (cp == CHK) begin
      w.kind    = k;
      w.slot    = SLOT_OUT_W'(slot);
      w.len     = len;
      w.arrival = arrival;
      w.ack     = ack;
      w.drop    = drop;
      w.last    = last;
      due_words.push_back(w);
    end
  endfunction

  // one header through the reorder logic; words are queued only for the checking copy
  function automatic void reorder_step(input int cp, input logic [KIND_W-1:0] kind,
                                       input logic [SEQ_W-1:0] seq,
                                       input logic [LEN_W-1:0] len_in);
    logic [LEN_W-1:0] len;
    logic [SEQ_W-1:0] seq_gap;
    logic             drop;
    int               slot;
    drop = 1'b0;
    if (is_closed[cp])
      return;
    len = (len_in > MAX_LEN) ? LEN_W'(MAX_LEN) : len_in;
    if (kind == MSG_FIN) begin
      push_word(cp, RES_FINACK, 0, '0, 1'b0, next_seq[cp], 1'b0, 1'b1);
      is_closed[cp] = 1'b1;
      return;
    end
    if (kind != MSG_DATA)
      return;
    if (seq == next_seq[cp]) begin
      // arriving payload goes out first, then the in-order run of buffered slots
      push_word(cp, RES_DELIVER, head_pos[cp], len, 1'b1, '0, 1'b0, 1'b0);
      slot_full[cp][head_pos[cp]] = 1'b0;
      head_pos[cp] = (head_pos[cp] + 1) % WIN;
      next_seq[cp] = next_seq[cp] + 1'b1;
      for (int i = 0; i < WIN && slot_full[cp][head_pos[cp]]; i++) begin
        push_word(cp, RES_DELIVER, head_pos[cp], slot_len[cp][head_pos[cp]], 1'b0, '0,
                  1'b0, 1'b0);
        slot_full[cp][head_pos[cp]] = 1'b0;
        head_pos[cp] = (head_pos[cp] + 1) % WIN;
        next_seq[cp] = next_seq[cp] + 1'b1;
      end
    end else if (seq > next_seq[cp]) begin
      seq_gap = seq - next_seq[cp];
      if (seq_gap < WIN) begin
        slot = (head_pos[cp] + int'(seq_gap)) % WIN;
        slot_full[cp][slot] = 1'b1;
        slot_len[cp][slot]  = len;
        push_word(cp, RES_STORE, slot, len, 1'b0, '0, 1'b0, 1'b0);
      end else begin
        drop = 1'b1;
      end
    end
    push_word(cp, RES_ACK, 0, '0, 1'b0, next_seq[cp], drop, 1'b1);
  endfunction

  // queue a header and advance the planning copy so later headers aim at the window
  function automatic void queue_header(input logic [KIND_W-1:0] kind,
                                       input logic [SEQ_W-1:0] seq,
                                       input logic [LEN_W-1:0] len);
    hdr_t h;
    h.kind        = kind;
    h.seq         = seq;
    h.len         = len;
    h.drain_first = pause_next;
    pause_next    = 1'b0;
    hdr_q.push_back(h);
    reorder_step(PLAN, kind, seq, len);
    if (kind == MSG_DATA)
      data_queued++;
  endfunction

  // lengths: mostly legal, some at the edges, some oversize
  function automatic logic [LEN_W-1:0] rand_len();
    int pick;
    pick = $urandom_range(0, 7);
    if (pick == 0)
      return LEN_W'($urandom_range(MAX_LEN + 1, (1 << LEN_W) - 1));
    if (pick == 1)
      return ($urandom_range(0, 2) == 0) ? '0 :
             ($urandom_range(0, 1) == 0) ? LEN_W'(MAX_LEN) : '1;
    return LEN_W'($urandom_range(0, MAX_LEN));
  endfunction

  // idle bursts on in stretches, none in the tail of the run
  function automatic logic idle_allowed();
    return (hdr_q.size() >= CALM_TAIL) && ((items_taken / 50) % 4 != 3);
  endfunction

  task automatic compare_field(input string fname, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $error("%s expected %0d got %0d", fname, want, got);
      mismatch_cnt++;
    end
  endtask

  // sender: offers queued headers, predicts on every accepted word
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && in_ready) begin
        reorder_step(CHK, msg_kind, seq_number, payload_length);
        items_taken++;
      end
      if (in_valid && !in_ready) begin
        // word stays put until taken
      end else if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (hdr_q.size() == 0 ||
                   (hdr_q[0].drain_first && due_words.size() != 0)) begin
        in_valid <= 1'b0;
      end else if (idle_allowed() && $urandom_range(0, 5) == 0) begin
        gap_left <= $urandom_range(0, 6);
        in_valid <= 1'b0;
      end else begin
        next_hdr       = hdr_q.pop_front();
        in_valid       <= 1'b1;
        msg_kind       <= next_hdr.kind;
        seq_number     <= next_hdr.seq;
        payload_length <= next_hdr.len;
      end
    end
  end

  // long receiver hold-off so the block backs up into its input
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && words_seen >= HOLD_AT_WORD) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // receiver: checks each accepted word against the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        words_seen++;
        if (due_words.size() == 0) begin
          $error("result word with nothing expected, result_kind %0d", result_kind);
          mismatch_cnt++;
        end else begin
          compare_field("result_kind", 32'(due_words[0].kind), 32'(result_kind));
          compare_field("slot_index", 32'(due_words[0].slot), 32'(slot_index));
          compare_field("delivered_length", 32'(due_words[0].len), 32'(delivered_length));
          compare_field("from_arrival", 32'(due_words[0].arrival), 32'(from_arrival));
          compare_field("ack_number", 32'(due_words[0].ack), 32'(ack_number));
          compare_field("dropped", 32'(due_words[0].drop), 32'(dropped));
          compare_field("last_of_run", 32'(due_words[0].last), 32'(last_of_run));
          void'(due_words.pop_front());
        end
      end
      if (stall_left != 0)
        stall_next = stall_left - 1;
      else if (idle_allowed() && $urandom_range(0, 7) == 0)
        stall_next = $urandom_range(1, 7);
      else
        stall_next = 0;
      stall_left <= stall_next;
      out_ready  <= (stall_next == 0) && (hold_left == 0);
    end
  end

  // ends the run when neither side moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int         pick;
    int         k;
    int         j;
    int         tmp;
    int         offs[WIN];
    logic [SEQ_W-1:0] s;
    logic       pause_set;

    clear_model();
    pause_set = 1'b0;

    // directed headers from reset
    queue_header(MSG_DATA, next_seq[PLAN], '0);
    queue_header(MSG_DATA, next_seq[PLAN], '1);                 // oversize saturates
    queue_header(MSG_DATA, next_seq[PLAN], LEN_W'(MAX_LEN));
    queue_header(MSG_OTHER, '1, '1);                            // ignored kind
    queue_header(MSG_RSVD, next_seq[PLAN], LEN_W'(5));          // ignored, looks in order
    queue_header(MSG_DATA, '0, LEN_W'(7));                      // behind, ack only
    queue_header(MSG_DATA, '1, LEN_W'(1));                      // far beyond, dropped
    queue_header(MSG_DATA, SEQ_W'(next_seq[PLAN] + WIN), LEN_W'(9)); // just past the window
    queue_header(MSG_DATA, SEQ_W'(next_seq[PLAN] + WIN - 1), '1);    // last slot of window
    queue_header(MSG_DATA, SEQ_W'(next_seq[PLAN] + WIN - 1), LEN_W'(12)); // duplicate
    queue_header(MSG_DATA, SEQ_W'(next_seq[PLAN] + 2), LEN_W'(300));
    queue_header(MSG_DATA, SEQ_W'(next_seq[PLAN] + 1), LEN_W'(MAX_LEN));
    queue_header(MSG_DATA, next_seq[PLAN], LEN_W'(1));          // delivers plus a short drain

    // random part: mostly window fills closed by the in-order packet
    data_queued = 0;
    k = WIN - 1;
    while (data_queued < RAND_ITEMS) begin
      if (!pause_set && data_queued >= PAUSE_AT_ITEM) begin
        pause_next = 1'b1;
        pause_set  = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 55 || k == WIN - 1) begin
        if (k != WIN - 1)
          k = ($urandom_range(0, 19) == 0) ? WIN - 1 : $urandom_range(0, 6);
        if (k == WIN - 1) begin
          // whole window in shuffled order, then a full drain
          for (j = 0; j < WIN - 1; j++)
            offs[j] = j + 1;
          for (j = WIN - 2; j > 0; j--) begin
            pick = $urandom_range(0, j);
            tmp = offs[j];
            offs[j] = offs[pick];
            offs[pick] = tmp;
          end
          for (j = 0; j < WIN - 1; j++)
            queue_header(MSG_DATA, SEQ_W'(next_seq[PLAN] + offs[j]), rand_len());
        end else begin
          for (j = 0; j < k; j++)
            queue_header(MSG_DATA, SEQ_W'(next_seq[PLAN] + $urandom_range(1, WIN - 1)),
                         rand_len());
        end
        queue_header(MSG_DATA, next_seq[PLAN], rand_len());
        k = 0;
      end else if (pick < 65) begin
        s = (next_seq[PLAN] == 0) ? '0 : SEQ_W'($urandom_range(0, next_seq[PLAN] - 1));
        queue_header(MSG_DATA, s, rand_len());
      end else if (pick < 75) begin
        if ($urandom_range(0, 2) == 0)
          s = SEQ_W'(next_seq[PLAN] + WIN + $urandom_range(0, 3));
        else
          s = SEQ_W'($urandom);
        queue_header(MSG_DATA, s, rand_len());
      end else if (pick < 85) begin
        queue_header(MSG_DATA, SEQ_W'(next_seq[PLAN] + $urandom_range(1, WIN - 1)),
                     rand_len());
      end else if (pick < 93) begin
        queue_header(MSG_DATA, next_seq[PLAN], rand_len());
      end else begin
        queue_header(($urandom_range(0, 1) == 0) ? MSG_OTHER : MSG_RSVD,
                     SEQ_W'($urandom), LEN_W'($urandom));
      end
    end

    // close, then headers that must be ignored after the fin
    queue_header(MSG_FIN, SEQ_W'($urandom), rand_len());
    queue_header(MSG_DATA, next_seq[PLAN], rand_len());
    queue_header(MSG_FIN, '0, '0);

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (hdr_q.size() != 0 || in_valid || due_words.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> selective_repeat_reorder_receiver.f
hdl/srr_pkg.sv
hdl/srr_ram.sv
hdl/srr_controller.sv
hdl/srr_datapath.sv
hdl/selective_repeat_reorder_receiver.sv
test/selective_repeat_reorder_receiver_tb.sv
